/* hw/rtl/bsr_pkg.sv */
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int IDX_W        = 64;
    localparam int BYTE_W       = 8;
    localparam int ROOM_W       = 7;
    localparam int CNT_W        = 7;
    localparam int DEF_CAPACITY = 64;
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              is_final;
        logic [ROOM_W-1:0] free_space;
    } t_in_word;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              stream_closed;
        logic [CNT_W-1:0]  pending_count;
        logic              last_of_run;
    } t_out_word;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              is_final;
        logic [ROOM_W-1:0] room;
        logic [IDX_W-1:0]  end_index;
    } t_cmd;

endpackage

/* hw/rtl/bsr_stream_if.sv */
`timescale 1ns / 1ps

interface bsr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/bsr_front.sv */
`timescale 1ns / 1ps

module bsr_front #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    bsr_stream_if.sink     i_in,
    input  logic           i_full,
    output logic           o_push,
    output bsr_pkg::t_cmd  o_cmd
);
    import bsr_pkg::*;

    always_comb begin
        i_in.ready = !i_full;
        o_push     = i_in.valid && !i_full;

        o_cmd.byte_index = i_in.data.byte_index;
        o_cmd.byte_value = i_in.data.byte_value;
        o_cmd.has_byte   = i_in.data.has_byte;
        o_cmd.is_final   = i_in.data.is_final;
        // room beyond the store size counts as the store size
        if (i_in.data.free_space > ROOM_W'(CAPACITY)) begin
            o_cmd.room = ROOM_W'(CAPACITY);
        end else begin
            o_cmd.room = i_in.data.free_space;
        end
        o_cmd.end_index = i_in.data.byte_index + IDX_W'(i_in.data.has_byte);
    end

endmodule

/* hw/rtl/bsr_queue.sv */
`timescale 1ns / 1ps

module bsr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsr_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output bsr_pkg::t_cmd  o_cmd
);
    import bsr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/bsr_back.sv */
`timescale 1ns / 1ps

module bsr_back #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  bsr_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    bsr_stream_if.source   o_out
);
    import bsr_pkg::*;

    localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W = ROOM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMPTY,
        S_RD,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [BYTE_W-1:0] r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [IDX_W-1:0]  r_ne;
    logic [SW-1:0]     r_head;
    logic [SW-1:0]     r_scan;
    logic              r_end_known;
    logic [IDX_W-1:0]  r_end_pos;
    logic [CNT_W-1:0]  r_held;
    logic              r_closed;
    logic              r_fin_closed;
    logic [ROOM_W-1:0] r_room;
    logic [CNT_W-1:0]  r_k;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [SW-1:0]     head_inc;
    logic [SW-1:0]     scan_inc;
    logic [IDX_W-1:0]  off;
    logic              in_win;
    logic [SUM_W-1:0]  slot_sum;
    logic [SW-1:0]     slot_w;
    logic              do_store;
    logic [IDX_W-1:0]  ne_fin;
    logic              out_free;
    logic              load_out;
    logic              closed_now;

    always_comb begin
        head_inc = (r_head == SW'(CAPACITY-1)) ? '0 : r_head + 1'b1;
        scan_inc = (r_scan == SW'(CAPACITY-1)) ? '0 : r_scan + 1'b1;

        // window check: next index <= byte index < next index + room
        off    = i_cmd.byte_index - r_ne;
        in_win = (i_cmd.byte_index >= r_ne) && (off[IDX_W-1:ROOM_W] == '0)
                 && (off[ROOM_W-1:0] < i_cmd.room);

        // slot of the byte: head slot plus offset, offset below capacity
        slot_sum = SUM_W'(r_head) + {1'b0, off[ROOM_W-1:0]};
        if (slot_sum >= SUM_W'(CAPACITY)) begin
            slot_sum = slot_sum - SUM_W'(CAPACITY);
        end
        slot_w = slot_sum[SW-1:0];

        o_pop    = (r_state == S_IDLE) && i_q_valid;
        do_store = o_pop && i_cmd.has_byte && !r_closed && in_win && !r_valid[slot_w];

        ne_fin     = r_ne + IDX_W'(r_k);
        closed_now = r_closed || (r_end_known && (ne_fin >= r_end_pos));
        out_free   = !r_out_valid || o_out.ready;
        load_out   = out_free && ((r_state == S_EMPTY) || (r_state == S_EMIT));
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[slot_w] <= i_cmd.byte_value;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_ne        <= '0;
            r_head      <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_held      <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_cmd.is_final) begin
                            r_end_known <= 1'b1;
                            r_end_pos   <= i_cmd.end_index;
                        end
                        if (do_store) begin
                            r_valid[slot_w] <= 1'b1;
                            r_held          <= r_held + 1'b1;
                        end
                        r_room  <= i_cmd.room;
                        r_k     <= '0;
                        r_scan  <= r_head;
                        r_state <= S_SCAN;
                    end
                end

                // count the in-order run first so every word carries the final closed flag
                S_SCAN: begin
                    if (!r_closed && (r_k != CNT_W'(r_room)) && r_valid[r_scan]) begin
                        r_k    <= r_k + 1'b1;
                        r_scan <= scan_inc;
                    end else begin
                        r_fin_closed <= closed_now;
                        r_state      <= (r_k == '0) ? S_EMPTY : S_RD;
                    end
                end

                S_EMPTY: begin
                    if (out_free) begin
                        r_out.out_valid     <= 1'b0;
                        r_out.out_byte      <= '0;
                        r_out.stream_closed <= r_fin_closed;
                        r_out.pending_count <= r_held;
                        r_out.last_of_run   <= 1'b1;
                        r_closed            <= r_fin_closed;
                        r_state             <= S_IDLE;
                    end
                end

                S_RD: begin
                    r_valid[r_head] <= 1'b0;
                    r_head          <= head_inc;
                    r_ne            <= r_ne + 1'b1;
                    r_held          <= r_held - 1'b1;
                    r_k             <= r_k - 1'b1;
                    r_state         <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out.out_valid     <= 1'b1;
                        r_out.out_byte      <= r_rd_data;
                        r_out.stream_closed <= r_fin_closed;
                        r_out.pending_count <= r_held;
                        r_out.last_of_run   <= (r_k == '0);
                        if (r_k == '0) begin
                            r_closed <= r_fin_closed;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/byte_stream_reassembler.sv */
// a word passes from the front into the queue and is popped by the back, which scans the
// in-order run of stored bytes, then reads and emits each byte in turn or gives an empty result;
// the back takes a new word from the queue only once it is through with the last, and its speed is
// set by the one-slot-per-cycle run scan and the single read port of the slot store
// reset (synchronous, active low) clears control, queue and all slot valid bits at once;
// slot data is not cleared and no clearing pass is needed
`timescale 1ns / 1ps

module byte_stream_reassembler #(
    parameter int CAPACITY = bsr_pkg::DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsr_stream_if.sink    i_in,
    bsr_stream_if.source  o_out
);
    import bsr_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_cmd cmd;
    t_cmd q_cmd;

    bsr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (cmd)
    );

    bsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bsr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
